@@ hw/rtl/time_window_reservation_arbiter_assert.svh @@
// ---------------------------------------------------------------------------
// Reservation arbiter assertion macros
// Thin wrappers so assertions vanish in synthesis builds.
// ---------------------------------------------------------------------------
`ifndef TIME_WINDOW_RESERVATION_ARBITER_ASSERT_SVH
`define TIME_WINDOW_RESERVATION_ARBITER_ASSERT_SVH
`ifndef SYNTHESIS
`define TWRA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define TWRA_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define TWRA_ASSERT(label, prop, msg)
`define TWRA_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

@@ hw/rtl/twra_pkg.sv @@
// ---------------------------------------------------------------------------
// Reservation arbiter package
// Shared sizes, result and request codes and the calendar entry type.
// ---------------------------------------------------------------------------
`default_nettype none
package twra_pkg;
  localparam int unsigned CalDepth = 8;
  localparam int unsigned IdxW     = $clog2(CalDepth);
  localparam int unsigned CntW     = $clog2(CalDepth + 1);

  typedef enum logic [2:0] {
    EvAccept   = 3'd0,
    EvConflict = 3'd1,
    EvFull     = 3'd2,
    EvStart    = 3'd3,
    EvEnd      = 3'd4
  } event_e;

  typedef enum logic {
    ReqSubmit = 1'b0,
    ReqTick   = 1'b1
  } req_e;

  typedef struct packed {
    logic [31:0] start;
    logic [30:0] length;
    logic [7:0]  prio;
    logic [7:0]  client;
  } entry_t;
endpackage
`default_nettype wire

@@ hw/rtl/time_window_reservation_arbiter.sv @@
// ---------------------------------------------------------------------------
// Time window reservation arbiter
// Sorted calendar of transmit-window reservations with preemption by priority.
// ---------------------------------------------------------------------------
// Usage: one input channel (valid_i/stall_o) carries submits and time ticks;
// one output channel (valid_o/stall_i) returns result transactions, the
// final one of each input flagged by last_o. A submit gives exactly one
// result; a tick gives zero to three (end, start, end).
// The block handles one transaction at a time. A shared compare unit walks
// the calendar one entry per cycle. A submit runs a scan pass over the
// waiting entries, a decide step, a compaction/insert pass and a result
// step; a rejected submit skips the compaction/insert pass. A tick checks
// the window end and the head entry, and when a window starts the calendar
// moves up by one entry. Each result sits in an output register; while
// the receiver stalls, a state with a result to give waits, but the scan,
// compaction and shift passes go on and may write the calendar. Reset empties
// the calendar and clears the active window; entry storage is not cleared.
// ---------------------------------------------------------------------------
`default_nettype none
`include "time_window_reservation_arbiter_assert.svh"
module time_window_reservation_arbiter (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  output logic             stall_o,
  input  wire logic        req_type_i,
  input  wire logic [31:0] start_ms_i,
  input  wire logic [30:0] duration_ms_i,
  input  wire logic [7:0]  priority_req_i,
  input  wire logic [7:0]  client_id_i,
  input  wire logic [31:0] now_ms_i,
  output logic             valid_o,
  input  wire logic        stall_i,
  output logic [2:0]       event_res_o,
  output logic [7:0]       event_client_o,
  output logic [3:0]       dropped_count_o,
  output logic             last_o
);
  import twra_pkg::*;

  typedef enum logic [8:0] {
    StIdle   = 9'b000000001,
    StScan   = 9'b000000010,
    StDecide = 9'b000000100,
    StMove   = 9'b000001000,
    StEmit   = 9'b000010000,
    StTEnd   = 9'b000100000,
    StTStart = 9'b001000000,
    StShift  = 9'b010000000,
    StTEnd2  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // Calendar storage
  entry_t cal_q [CalDepth];
  logic [CntW-1:0] count_q, count_d;
  logic            win_act_q, win_act_d;
  logic [31:0]     win_end_q, win_end_d;
  logic [7:0]      win_cli_q, win_cli_d;

  // Request registers
  entry_t          req_q;
  logic [31:0]     now_q;

  // Sequencer working state
  logic [CntW-1:0] idx_q, idx_d;     // read pointer
  logic [CntW-1:0] wr_q, wr_d;       // write pointer
  logic [CalDepth-1:0] hit_q, hit_d;
  logic            conf_q, conf_d;
  logic [CntW-1:0] ndrop_q, ndrop_d;
  logic            ins_q, ins_d;     // new entry placed
  entry_t          carry_q, carry_d; // survivor displaced by the insert
  logic            endp_q, endp_d;   // window end waiting to be reported

  // Output register
  logic            ovld_q, ovld_d;
  logic [2:0]      ores_q, ores_d;
  logic [7:0]      ocli_q, ocli_d;
  logic [3:0]      odrop_q, odrop_d;
  logic            olast_q, olast_d;

  // Calendar write port
  logic            we;
  logic [IdxW-1:0] waddr;
  entry_t          wdata;

  logic            out_free;
  assign out_free = !ovld_q || !stall_i;

  // Shared read and compare unit
  entry_t          rd;
  logic [IdxW-1:0] ridx;
  logic [32:0]     a_end, b_end;
  logic            overlap, place_here, rd_ok;
  logic [31:0]     diff;
  logic [31:0]     tmark;
  logic            start_due;

  assign ridx  = idx_q[IdxW-1:0];
  assign rd_ok = idx_q < count_q;
  assign rd    = cal_q[ridx];
  assign a_end = {1'b0, req_q.start} + {2'b0, req_q.length};
  assign b_end = {1'b0, rd.start} + {2'b0, rd.length};
  assign overlap = !((a_end <= {1'b0, rd.start}) || (b_end <= {1'b0, req_q.start}));
  assign place_here = (req_q.start < rd.start) ||
                      ((req_q.start == rd.start) && (req_q.prio > rd.prio));

  // Wrap-aware time check, shared by end and start tests
  always_comb begin
    unique case (state_q)
      StTStart: tmark = rd.start;
      default:  tmark = win_end_q;
    endcase
  end
  assign diff = now_q - tmark;
  assign start_due = !win_act_q && (count_q != '0) && !diff[31];

  logic [CntW-1:0] keep_cnt;
  assign keep_cnt = count_q - ndrop_q;

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    win_act_d = win_act_q;
    win_end_d = win_end_q;
    win_cli_d = win_cli_q;
    idx_d     = idx_q;
    wr_d      = wr_q;
    hit_d     = hit_q;
    conf_d    = conf_q;
    ndrop_d   = ndrop_q;
    ins_d     = ins_q;
    carry_d   = carry_q;
    endp_d    = endp_q;
    ovld_d    = ovld_q && stall_i;
    ores_d    = ores_q;
    ocli_d    = ocli_q;
    odrop_d   = odrop_q;
    olast_d   = olast_q;
    we        = 1'b0;
    waddr     = wr_q[IdxW-1:0];
    wdata     = rd;
    unique case (state_q)
      StIdle: begin
        if (valid_i) begin
          idx_d   = '0;
          wr_d    = '0;
          hit_d   = '0;
          conf_d  = 1'b0;
          ndrop_d = '0;
          ins_d   = 1'b0;
          endp_d  = 1'b0;
          state_d = (req_type_i == ReqTick) ? StTEnd : StScan;
        end
      end
      // Check one waiting entry per cycle for overlap
      StScan: begin
        if (rd_ok) begin
          if (overlap) begin
            if (rd.prio >= req_q.prio) begin
              conf_d = 1'b1;
            end else begin
              hit_d[ridx] = 1'b1;
              ndrop_d     = ndrop_q + 1'b1;
            end
          end
          idx_d = idx_q + 1'b1;
        end else begin
          state_d = StDecide;
        end
      end
      StDecide: begin
        idx_d = '0;
        if (conf_q || (keep_cnt >= CntW'(CalDepth))) begin
          state_d = StEmit;
        end else begin
          state_d = StMove;
        end
      end
      // Compact survivors and insert the new entry in one pass; after the
      // insert each survivor is delayed one slot through the carry
      // register, so no slot is written before it has been read.
      StMove: begin
        if (rd_ok && hit_q[ridx]) begin
          idx_d = idx_q + 1'b1;
        end else if (rd_ok) begin
          we    = 1'b1;
          wr_d  = wr_q + 1'b1;
          idx_d = idx_q + 1'b1;
          if (ins_q) begin
            wdata   = carry_q;
            carry_d = rd;
          end else if (place_here) begin
            wdata   = req_q;
            carry_d = rd;
            ins_d   = 1'b1;
          end else begin
            wdata = rd;
          end
        end else begin
          // Write the last carried survivor, or the new entry at the tail
          we      = 1'b1;
          wdata   = ins_q ? carry_q : req_q;
          ins_d   = 1'b1;
          count_d = wr_q + 1'b1;
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (out_free) begin
          ovld_d  = 1'b1;
          ores_d  = conf_q ? EvConflict : (ins_q ? EvAccept : EvFull);
          ocli_d  = req_q.client;
          odrop_d = ins_q ? ((ndrop_q > CntW'(15)) ? 4'd15 : 4'(ndrop_q)) : 4'd0;
          olast_d = 1'b1;
          state_d = StIdle;
        end
      end
      // Close the active window when due; report it once the start is known
      StTEnd: begin
        if (win_act_q && !diff[31]) begin
          win_act_d = 1'b0;
          endp_d    = 1'b1;
        end
        state_d = StTStart;
      end
      // Report a pending end, then start the head entry when due
      StTStart: begin
        if (endp_q) begin
          if (out_free) begin
            ovld_d  = 1'b1;
            ores_d  = EvEnd;
            ocli_d  = win_cli_q;
            odrop_d = '0;
            olast_d = !start_due;
            endp_d  = 1'b0;
          end
        end else if (start_due) begin
          if (out_free) begin
            win_cli_d = rd.client;
            win_end_d = now_q + {1'b0, rd.length};
            win_act_d = 1'b1;
            ovld_d    = 1'b1;
            ores_d    = EvStart;
            ocli_d    = rd.client;
            odrop_d   = '0;
            olast_d   = (rd.length != '0);
            idx_d     = CntW'(1);
            wr_d      = '0;
            state_d   = StShift;
          end
        end else begin
          state_d = StIdle;
        end
      end
      // Move the calendar up by one entry
      StShift: begin
        if (rd_ok) begin
          we    = 1'b1;
          wdata = rd;
          wr_d  = wr_q + 1'b1;
          idx_d = idx_q + 1'b1;
        end else begin
          count_d = count_q - 1'b1;
          state_d = StTEnd2;
        end
      end
      // Zero-length window ends in the same tick
      StTEnd2: begin
        if (!diff[31]) begin
          if (out_free) begin
            ovld_d    = 1'b1;
            ores_d    = EvEnd;
            ocli_d    = win_cli_q;
            odrop_d   = '0;
            olast_d   = 1'b1;
            win_act_d = 1'b0;
            state_d   = StIdle;
          end
        end else begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      cal_q[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && valid_i) begin
      req_q.start  <= start_ms_i;
      req_q.length <= duration_ms_i;
      req_q.prio   <= priority_req_i;
      req_q.client <= client_id_i;
      now_q        <= now_ms_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      count_q   <= '0;
      win_act_q <= 1'b0;
      win_end_q <= '0;
      win_cli_q <= '0;
      idx_q     <= '0;
      wr_q      <= '0;
      hit_q     <= '0;
      conf_q    <= 1'b0;
      ndrop_q   <= '0;
      ins_q     <= 1'b0;
      carry_q   <= '0;
      endp_q    <= 1'b0;
      ovld_q    <= 1'b0;
      ores_q    <= EvAccept;
      ocli_q    <= '0;
      odrop_q   <= '0;
      olast_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      win_act_q <= win_act_d;
      win_end_q <= win_end_d;
      win_cli_q <= win_cli_d;
      idx_q     <= idx_d;
      wr_q      <= wr_d;
      hit_q     <= hit_d;
      conf_q    <= conf_d;
      ndrop_q   <= ndrop_d;
      ins_q     <= ins_d;
      carry_q   <= carry_d;
      endp_q    <= endp_d;
      ovld_q    <= ovld_d;
      ores_q    <= ores_d;
      ocli_q    <= ocli_d;
      odrop_q   <= odrop_d;
      olast_q   <= olast_d;
    end
  end

  assign stall_o         = (state_q != StIdle);
  assign valid_o         = ovld_q;
  assign event_res_o     = ores_q;
  assign event_client_o  = ocli_q;
  assign dropped_count_o = odrop_q;
  assign last_o          = olast_q;

  `TWRA_ASSERT(a_count_max, (count_q <= CntW'(CalDepth)), "calendar count over depth")
  `TWRA_ASSERT(a_onehot, ($onehot(state_q)), "state not one-hot")
  `TWRA_ASSERT_NEXT(a_out_hold, (valid_o && stall_i), (valid_o && $stable(event_res_o)), "stalled result changed")
  `TWRA_ASSERT(a_drop_zero, (!valid_o || event_res_o == EvAccept || dropped_count_o == '0), "drop count on non-accept result")
endmodule
`default_nettype wire

@@ tb/sv/time_window_reservation_arbiter_tb.sv @@
// ---------------------------------------------------------------------------
// Time window reservation arbiter testbench
// Drives submits and ticks with random gaps. A model of the sorted calendar
// predicts every result. The monitor checks each result field by field, in
// order, under random receiver stalls.
// ---------------------------------------------------------------------------
`default_nettype none
module time_window_reservation_arbiter_tb;
  import twra_pkg::*;

  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned DrainCycles   = 60;

  typedef struct {
    req_e        kind;
    logic [31:0] start;
    logic [30:0] dur;
    logic [7:0]  prio;
    logic [7:0]  client;
    logic [31:0] now;
    bit          hold;    // wait for every result before sending this one
  } request_t;

  typedef struct {
    event_e      res;
    logic [7:0]  client;
    logic [3:0]  dropped;
    logic        last;
  } outcome_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        valid_i = 1'b0;
  logic        req_type_i = 1'b0;
  logic [31:0] start_ms_i = '0;
  logic [30:0] duration_ms_i = '0;
  logic [7:0]  priority_req_i = '0;
  logic [7:0]  client_id_i = '0;
  logic [31:0] now_ms_i = '0;
  logic        stall_i = 1'b0;
  logic        stall_o;
  logic        valid_o;
  logic [2:0]  event_res_o;
  logic [7:0]  event_client_o;
  logic [3:0]  dropped_count_o;
  logic        last_o;

  time_window_reservation_arbiter uut (.*);

  always #6 clk_i = ~clk_i;

  // Calendar model
  entry_t      cal[CalDepth];
  int unsigned cal_len = 0;
  bit          win_on = 1'b0;
  logic [31:0] win_end = '0;
  logic [7:0]  win_client = '0;

  request_t pending_reqs[$];
  outcome_t expected_events[$];
  int unsigned errors = 0;
  int unsigned n_sent = 0, n_results = 0, n_starts = 0, n_drops = 0;
  bit          stim_done = 1'b0;
  logic [31:0] clock_ms = '0;

  function automatic bit reached(logic [31:0] now, logic [31:0] mark);
    logic [31:0] diff;
    diff = now - mark;
    return !diff[31];
  endfunction

  function automatic void push_event(event_e r, logic [7:0] c, int unsigned d);
    outcome_t o;
    o.res = r; o.client = c; o.dropped = 4'(d); o.last = 1'b0;
    expected_events.push_back(o);
  endfunction

  // Predict the results of one request and update the calendar model
  function automatic void predict_request(request_t q);
    int unsigned n_before, ndrop, j, pos;
    bit          conflict;
    bit          hit[CalDepth];
    logic [32:0] a_end, b_end;
    entry_t      ne;
    n_before = expected_events.size();
    if (q.kind == ReqSubmit) begin
      conflict = 1'b0; ndrop = 0;
      a_end = {1'b0, q.start} + {2'b0, q.dur};
      for (int i = 0; i < cal_len; i++) begin
        b_end = {1'b0, cal[i].start} + {2'b0, cal[i].length};
        hit[i] = 1'b0;
        if (!(a_end <= {1'b0, cal[i].start} || b_end <= {1'b0, q.start})) begin
          if (cal[i].prio >= q.prio) conflict = 1'b1;
          else begin hit[i] = 1'b1; ndrop++; end
        end
      end
      if (conflict) push_event(EvConflict, q.client, 0);
      else if (cal_len - ndrop >= CalDepth) push_event(EvFull, q.client, 0);
      else begin
        j = 0;
        for (int i = 0; i < cal_len; i++)
          if (!hit[i]) begin cal[j] = cal[i]; j++; end
        cal_len = j;
        pos = 0;
        while (pos < cal_len && !(q.start < cal[pos].start ||
               (q.start == cal[pos].start && q.prio > cal[pos].prio)))
          pos++;
        for (int i = cal_len; i > pos; i--) cal[i] = cal[i-1];
        ne.start = q.start; ne.length = q.dur; ne.prio = q.prio; ne.client = q.client;
        cal[pos] = ne;
        cal_len++;
        n_drops += ndrop;
        push_event(EvAccept, q.client, ndrop);
      end
    end else begin
      if (win_on && reached(q.now, win_end)) begin
        push_event(EvEnd, win_client, 0);
        win_on = 1'b0;
      end
      if (!win_on && cal_len > 0 && reached(q.now, cal[0].start)) begin
        win_client = cal[0].client;
        win_end = q.now + 32'(cal[0].length);
        win_on = 1'b1;
        push_event(EvStart, win_client, 0);
        n_starts++;
        for (int i = 0; i + 1 < cal_len; i++) cal[i] = cal[i+1];
        cal_len--;
        if (reached(q.now, win_end)) begin
          push_event(EvEnd, win_client, 0);
          win_on = 1'b0;
        end
      end
    end
    if (expected_events.size() > n_before)
      expected_events[expected_events.size()-1].last = 1'b1;
  endfunction

  function automatic void add_submit(logic [31:0] s, logic [30:0] d, logic [7:0] p,
                                     logic [7:0] c);
    request_t q;
    q.kind = ReqSubmit; q.start = s; q.dur = d; q.prio = p; q.client = c;
    q.now = $urandom; q.hold = 1'b0;
    pending_reqs.push_back(q);
  endfunction

  function automatic void add_tick(logic [31:0] now, bit hold);
    request_t q;
    q.kind = ReqTick; q.now = now; q.hold = hold;
    q.start = $urandom; q.dur = 31'($urandom); q.prio = 8'($urandom);
    q.client = 8'($urandom);
    pending_reqs.push_back(q);
  endfunction

  // Fill the request queue: directed cases, then random traffic
  initial begin
    logic [31:0] base;
    // conflict, preemption, equal priority order, full calendar
    add_submit(32'd100, 31'd50, 8'd10, 8'h01);
    add_submit(32'd120, 31'd10, 8'd10, 8'h02);   // equal priority overlap
    add_submit(32'd120, 31'd10, 8'd5,  8'h03);   // lower priority overlap
    add_submit(32'd90,  31'd100, 8'd200, 8'h04); // preempt one
    add_submit(32'd190, 31'd0, 8'd1, 8'h05);     // zero length touching end
    for (int i = 0; i < 8; i++)
      add_submit(32'd1000 + 32'(i) * 10, 31'd5, 8'(i), 8'(16 + i));
    add_submit(32'd2000, 31'd5, 8'd0, 8'hFE);    // calendar full
    add_submit(32'd995, 31'd200, 8'hFF, 8'hFF);  // preempt many
    add_submit(32'hFFFF_FFFF, 31'h7FFF_FFFF, 8'd0, 8'h00);
    add_tick(32'd0, 1'b0);
    add_tick(32'd100, 1'b0);
    add_tick(32'd5000, 1'b0);
    add_tick(32'd5000, 1'b1);
    add_tick(32'hFFFF_FFFF, 1'b0);
    add_tick(32'h8000_0000, 1'b0);
    add_tick(32'h7FFF_FFFF, 1'b0);
    add_tick(32'hFFFF_FFF0, 1'b1);
    // random: a running clock near the window times, with some wild values
    base = $urandom;
    for (int i = 0; i < 456; i++) begin
      case ($urandom_range(0, 9))
        0: add_submit($urandom, 31'($urandom), 8'($urandom), 8'($urandom));
        1, 2, 3, 4: add_submit(base + $urandom_range(0, 400),
                               31'($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 60)),
                               8'($urandom_range(0, 15)), 8'($urandom));
        9: add_tick($urandom, i % 97 == 50);
        default: begin
          base = base + $urandom_range(0, 80);
          add_tick(base, i % 97 == 50);
        end
      endcase
    end
  end

  // Reset once
  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Driver
  int unsigned send_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_i && !stall_o) begin
        n_sent++;
        send_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
      end
      if (!(valid_i && stall_o)) begin
        if (send_gap > 0) begin
          send_gap--;
          valid_i <= 1'b0;
        end else if (pending_reqs.size() > 0 &&
                     !(pending_reqs[0].hold && expected_events.size() > 0)) begin
          request_t q;
          q = pending_reqs.pop_front();
          predict_request(q);
          valid_i <= 1'b1;
          req_type_i <= q.kind;
          start_ms_i <= q.start;
          duration_ms_i <= q.dur;
          priority_req_i <= q.prio;
          client_id_i <= q.client;
          now_ms_i <= q.now;
        end else begin
          valid_i <= 1'b0;
          if (pending_reqs.size() == 0) stim_done = 1'b1;
        end
      end
    end
  end

  // Monitor with random receiver stalls
  int unsigned stall_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_o && !stall_i) begin
        outcome_t e;
        n_results++;
        if (expected_events.size() == 0) begin
          $error("unexpected result: event_res %0d client %0d", event_res_o, event_client_o);
          errors++;
        end else begin
          e = expected_events.pop_front();
          if (event_res_o !== e.res) begin
            $error("event_res expected %0d actual %0d", e.res, event_res_o); errors++;
          end
          if (event_client_o !== e.client) begin
            $error("event_client expected %0d actual %0d", e.client, event_client_o); errors++;
          end
          if (dropped_count_o !== e.dropped) begin
            $error("dropped_count expected %0d actual %0d", e.dropped, dropped_count_o);
            errors++;
          end
          if (last_o !== e.last) begin
            $error("last expected %0d actual %0d", e.last, last_o); errors++;
          end
        end
        stall_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 15);
      end
      if (stall_left > 0) begin
        stall_left--;
        stall_i <= 1'b1;
      end else begin
        stall_i <= 1'b0;
      end
    end
  end

  // Watchdog and end of run
  initial begin
    int unsigned idle;
    idle = 0;
    wait (rst_ni);
    while (!(stim_done && !valid_i && expected_events.size() == 0)) begin
      @(posedge clk_i);
      if ((valid_i && !stall_o) || (valid_o && !stall_i)) idle = 0;
      else idle++;
      if (idle >= WatchdogLimit) begin
        $display("timeout with %0d results outstanding", expected_events.size());
        $display("Verification failed");
        $finish;
      end
    end
    repeat (DrainCycles) @(posedge clk_i);
    $display("covered %0d requests, %0d results, %0d window starts, %0d preemptions",
             n_sent, n_results, n_starts, n_drops);
    if (errors == 0 && expected_events.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/twra_pkg.sv
hw/rtl/time_window_reservation_arbiter.sv
tb/sv/time_window_reservation_arbiter_tb.sv
